@@ hw/rtl/gtd_pkg.sv @@
// Shared types and constants for the gesture turn direction unit.
// No dependencies.
package gtd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned TurnW  = 11;

  localparam logic [1:0] SeenFull = 2'd3;
  localparam logic [1:0] SeenTwo  = 2'd2;
  localparam logic [1:0] SeenOne  = 2'd1;
  localparam logic [1:0] SeenNone = 2'd0;

  typedef struct packed {
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } point_t;

  // cross product of a triple is lhs - rhs
  typedef struct packed {
    logic signed [ProdW-1:0] lhs;
    logic signed [ProdW-1:0] rhs;
  } prod_t;

endpackage

@@ hw/rtl/gtd_cross.sv @@
// Cross product terms for one triple of points a, b, c.
// Depends on gtd_pkg.
module gtd_cross import gtd_pkg::*; (
  input  point_t a_i,
  input  point_t b_i,
  input  point_t c_i,
  output prod_t  prod_o
);

  logic signed [DiffW-1:0] dx_ab, dy_ab, dx_bc, dy_bc;

  assign dx_ab = $signed({1'b0, b_i.x}) - $signed({1'b0, a_i.x});
  assign dy_ab = $signed({1'b0, b_i.y}) - $signed({1'b0, a_i.y});
  assign dx_bc = $signed({1'b0, c_i.x}) - $signed({1'b0, b_i.x});
  assign dy_bc = $signed({1'b0, c_i.y}) - $signed({1'b0, b_i.y});

  assign prod_o.lhs = dx_ab * dy_bc;
  assign prod_o.rhs = dy_ab * dx_bc;

endmodule

@@ hw/rtl/gesture_turn_direction_unit.sv @@
// Gesture turn direction unit: cross-product vote over the points of a gesture.
// Depends on gtd_pkg and gtd_cross.
//
// Accepts one touch point per cycle while in_stall_o is low; a result beat appears
// only for a final point, after the input, product and output registers, and later
// while the output is stalled. The rate is set by the cross-product stage: the three
// triples that a final point closes are multiplied in parallel (six 17x17
// multipliers) and registered, and the vote is folded in the next cycle. A stalled
// result holds back the pipe only when a further final point reaches the vote stage.
module gesture_turn_direction_unit import gtd_pkg::*; #(
  parameter int unsigned MAX_POINTS = 512
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CoordW-1:0]       point_x_i,
  input  logic [CoordW-1:0]       point_y_i,
  input  logic                    final_point_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    clockwise_o,
  output logic signed [TurnW-1:0] turn_vote_o
);

  localparam int unsigned VoteW = $clog2(MAX_POINTS + 1) + 1;
  localparam logic signed [VoteW-1:0] VoteMax = VoteW'(MAX_POINTS);
  localparam logic signed [VoteW-1:0] VoteMin = -VoteMax;

  function automatic logic signed [VoteW-1:0] sat_step(
    input logic signed [VoteW-1:0] v,
    input prod_t                   p
  );
    logic signed [VoteW-1:0] r;
    r = v;
    if (p.lhs > p.rhs) begin
      if (v < VoteMax) r = v + VoteW'(1);
    end else if (p.lhs < p.rhs) begin
      if (v > VoteMin) r = v - VoteW'(1);
    end
    return r;
  endfunction

  // input stage
  logic   s0_vld_q;
  point_t s0_pt_q;
  logic   s0_fin_q;

  // point history
  point_t     first_q, second_q, older_q, newer_q;
  logic [1:0] seen_q;

  // product stage
  logic  s1_vld_q, s1_fin_q, s1_use_q;
  prod_t s1_prod_q [3];
  prod_t prod [3];

  logic signed [VoteW-1:0] vote_q, vote_d, v1, v2;
  logic signed [VoteW+TurnW-1:0] vote_ext;

  logic out_vld_q, cw_q;
  logic signed [TurnW-1:0] turn_q;

  logic s1_adv, s1_free, s0_adv, s0_free, in_acc, out_take, s0_use;

  assign out_take = out_vld_q & ~out_stall_i;
  assign s1_adv   = s1_vld_q & (~s1_fin_q | ~out_vld_q | ~out_stall_i);
  assign s1_free  = ~s1_vld_q | s1_adv;
  assign s0_adv   = s0_vld_q & s1_free;
  assign s0_free  = ~s0_vld_q | s0_adv;
  assign in_acc   = in_valid_i & s0_free;
  assign in_stall_o = ~s0_free;
  assign s0_use   = (seen_q == SeenTwo) || (seen_q == SeenFull);

  gtd_cross u_cross_cur (.a_i(older_q), .b_i(newer_q),  .c_i(s0_pt_q),  .prod_o(prod[0]));
  gtd_cross u_cross_wr0 (.a_i(newer_q), .b_i(s0_pt_q),  .c_i(first_q),  .prod_o(prod[1]));
  gtd_cross u_cross_wr1 (.a_i(s0_pt_q), .b_i(first_q),  .c_i(second_q), .prod_o(prod[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_free) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_pt_q  <= '{y: point_y_i, x: point_x_i};
      s0_fin_q <= final_point_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      older_q  <= '0;
      newer_q  <= '0;
      seen_q   <= SeenNone;
    end else if (s0_adv) begin
      if (s0_fin_q) begin
        first_q  <= '0;
        second_q <= '0;
        older_q  <= '0;
        newer_q  <= '0;
        seen_q   <= SeenNone;
      end else begin
        if (seen_q == SeenNone) first_q  <= s0_pt_q;
        if (seen_q == SeenOne)  second_q <= s0_pt_q;
        older_q <= newer_q;
        newer_q <= s0_pt_q;
        if (seen_q != SeenFull) seen_q <= seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s0_adv) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      s1_fin_q  <= s0_fin_q;
      s1_use_q  <= s0_use;
      s1_prod_q <= prod;
    end
  end

  // vote fold: current triple, then the two wrap triples on a final point
  always_comb begin
    v1 = s1_use_q ? sat_step(vote_q, s1_prod_q[0]) : vote_q;
    v2 = (s1_fin_q && s1_use_q) ? sat_step(sat_step(v1, s1_prod_q[1]), s1_prod_q[2]) : v1;
    vote_d   = s1_fin_q ? '0 : v2;
    vote_ext = {{TurnW{v2[VoteW-1]}}, v2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vote_q <= '0;
    end else if (s1_adv) begin
      vote_q <= vote_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv && s1_fin_q) begin
      out_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_fin_q) begin
      cw_q   <= s1_use_q ? (v2 > VoteW'(0)) : 1'b1;
      turn_q <= s1_use_q ? vote_ext[TurnW-1:0] : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign clockwise_o = cw_q;
  assign turn_vote_o = turn_q;

endmodule

@@ hw/rtl/gtd_checker.sv @@
// Port-level checks for the gesture turn direction unit, bound to the top level.
// Depends on gtd_pkg and gesture_turn_direction_unit.
module gtd_checker import gtd_pkg::*; #(
  parameter int unsigned MAX_POINTS = 512
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [CoordW-1:0]       point_x_i,
  input logic [CoordW-1:0]       point_y_i,
  input logic                    final_point_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic                    clockwise_o,
  input logic signed [TurnW-1:0] turn_vote_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(clockwise_o) && $stable(turn_vote_o))
    else $error("result beat changed under stall");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // direction agrees with the sign of the vote
  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (MAX_POINTS <= 1023) |->
      !(clockwise_o && (turn_vote_o < 0)) && !(!clockwise_o && (turn_vote_o > 0)))
    else $error("direction disagrees with vote");

  // vote stays inside the bound
  a_vote_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (MAX_POINTS <= 1023) |->
      (int'(turn_vote_o) <= int'(MAX_POINTS)) && (int'(turn_vote_o) >= -int'(MAX_POINTS)))
    else $error("vote out of range");

  // a fresh result follows a final point taken at the input
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && final_point_i, 3))
    else $error("result without a final point");

endmodule

bind gesture_turn_direction_unit gtd_checker #(.MAX_POINTS(MAX_POINTS)) u_gtd_checker (.*);

@@ bench/testbench.sv @@
// Self-checking bench for gesture_turn_direction_unit: directed gestures, saturating loops, then random ones.
// Checks each result beat against a typed expectation or a cross-product vote predictor kept in this file.
// Depends on gtd_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
  import gtd_pkg::*;

  localparam int MaxVote = 512;
  localparam int RandomItems = 180;
  localparam int SatRepeats = 175;

  typedef struct packed {
    logic                    cw;
    logic signed [TurnW-1:0] vote;
  } turn_t;

  typedef struct packed {
    logic [CoordW-1:0]       x;
    logic [CoordW-1:0]       y;
    logic                    fin;
    logic                    typed;
    logic                    cw;
    logic signed [TurnW-1:0] vote;
  } step_row_t;

  // typed rows: lone point, pair, triangles both ways, repeated point, collinear line
  localparam step_row_t Steps [24] = '{
    '{16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 11'sd0},
    '{16'd65535, 16'd65535, 1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 11'sd0},
    '{16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd65535, 16'd0,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd0,     16'd65535, 1'b1, 1'b1, 1'b1, 11'sd3},
    '{16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd0,     16'd65535, 1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd65535, 16'd0,     1'b1, 1'b1, 1'b0, -11'sd3},
    '{16'd65535, 16'd0,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd65535, 16'd0,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd65535, 16'd0,     1'b1, 1'b1, 1'b0, 11'sd0},
    '{16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd32768, 16'd32768, 1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd65535, 16'd65535, 1'b1, 1'b1, 1'b0, 11'sd0},
    '{16'd100,   16'd200,   1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd100,   16'd200,   1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd5000,  16'd300,   1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd2000,  16'd9000,  1'b1, 1'b0, 1'b0, 11'sd0},
    '{16'd65535, 16'd32768, 1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd1,     16'd65535, 1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd40000, 16'd1,     1'b0, 1'b0, 1'b0, 11'sd0},
    '{16'd65534, 16'd65534, 1'b1, 1'b0, 1'b0, 11'sd0}
  };

  localparam int OctDx [8] = '{900, 636, 0, -636, -900, -636, 0, 636};
  localparam int OctDy [8] = '{0, 636, 900, 636, 0, -636, -900, -636};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CoordW-1:0] point_x_i = '0;
  logic [CoordW-1:0] point_y_i = '0;
  logic              final_point_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              clockwise_o;
  logic signed [TurnW-1:0] turn_vote_o;

  gesture_turn_direction_unit #(.MAX_POINTS(MaxVote)) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .point_x_i,
    .point_y_i,
    .final_point_i,
    .out_valid_o,
    .out_stall_i,
    .clockwise_o,
    .turn_vote_o
  );

  // predictor state
  point_t     first_p, second_p, older_p, newer_p;
  logic [1:0] seen_pts;
  int         vote_acc;

  turn_t pending_turns [$];
  int    mismatches = 0;
  int    items_sent = 0;
  bit    quiet = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  task automatic clear_gesture();
    first_p = '0;
    second_p = '0;
    older_p = '0;
    newer_p = '0;
    seen_pts = SeenNone;
    vote_acc = 0;
  endtask

  task automatic tally_triple(input point_t a, input point_t b, input point_t c);
    longint cp;
    cp = (longint'(b.x) - longint'(a.x)) * (longint'(c.y) - longint'(b.y))
       - (longint'(b.y) - longint'(a.y)) * (longint'(c.x) - longint'(b.x));
    if (cp > 0) begin
      if (vote_acc < MaxVote) vote_acc++;
    end else if (cp < 0) begin
      if (vote_acc > -MaxVote) vote_acc--;
    end
  endtask

  task automatic fold_point(input point_t p, input logic last, output bit got,
                            output turn_t r);
    got = 1'b0;
    r = '0;
    if (seen_pts >= SeenTwo) tally_triple(older_p, newer_p, p);
    if (seen_pts == SeenNone) first_p = p;
    else if (seen_pts == SeenOne) second_p = p;
    older_p = newer_p;
    newer_p = p;
    if (seen_pts != SeenFull) seen_pts++;
    if (last) begin
      got = 1'b1;
      if (seen_pts == SeenFull) begin
        tally_triple(older_p, newer_p, first_p);
        tally_triple(newer_p, first_p, second_p);
        r.cw = vote_acc > 0;
        r.vote = vote_acc[TurnW-1:0];
      end else begin
        r.cw = 1'b1;
        r.vote = '0;
      end
      clear_gesture();
    end
  endtask

  task automatic offer_point(input point_t p, input logic last, input bit typed,
                             input turn_t typed_r);
    bit    got;
    turn_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= p.x;
    point_y_i <= p.y;
    final_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    fold_point(p, last, got, r);
    if (got) pending_turns.push_back(typed ? typed_r : r);
  endtask

  task automatic play_gesture(input point_t pts [$]);
    foreach (pts[i]) offer_point(pts[i], i == pts.size() - 1, 1'b0, '0);
  endtask

  function automatic point_t any_point();
    point_t p;
    p.x = CoordW'($urandom);
    p.y = CoordW'($urandom);
    return p;
  endfunction

  task automatic random_gesture();
    point_t pts [$];
    point_t p;
    int kind, n, s, dir, cx, cy, k;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      n = $urandom_range(3, 10);
      repeat (n) pts.push_back(any_point());
    end else if (kind < 65) begin
      // convex run of octagon vertices, either turning sense
      n = $urandom_range(3, 8);
      s = $urandom_range(0, 7);
      dir = $urandom_range(0, 1) ? 1 : 7;
      cx = $urandom_range(1000, 64535);
      cy = $urandom_range(1000, 64535);
      for (int i = 0; i < n; i++) begin
        k = (s + i * dir) % 8;
        p.x = CoordW'(cx + OctDx[k]);
        p.y = CoordW'(cy + OctDy[k]);
        pts.push_back(p);
      end
    end else if (kind < 80) begin
      // tiny grid: repeats, collinear and zero products
      n = $urandom_range(1, 8);
      repeat (n) begin
        p.x = CoordW'($urandom_range(0, 3));
        p.y = CoordW'($urandom_range(0, 3));
        pts.push_back(p);
      end
    end else if (kind < 90) begin
      n = $urandom_range(1, 2);
      repeat (n) pts.push_back(any_point());
    end else begin
      n = $urandom_range(3, 15);
      p = any_point();
      repeat (n) begin
        if ($urandom_range(0, 2) != 0) p = any_point();
        pts.push_back(p);
      end
    end
    play_gesture(pts);
  endtask

  // long triangle loops drive the vote into both bounds
  task automatic saturating_gesture(input point_t a, input point_t b, input point_t c);
    point_t pts [$];
    repeat (SatRepeats) begin
      pts.push_back(a);
      pts.push_back(b);
      pts.push_back(c);
    end
    play_gesture(pts);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    turn_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_turns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: clockwise %0b vote %0d", clockwise_o, turn_vote_o);
      end else begin
        want = pending_turns.pop_front();
        if (clockwise_o !== want.cw || turn_vote_o !== want.vote) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: clockwise exp %0b got %0b, vote exp %0d got %0d",
                     want.cw, clockwise_o, want.vote, turn_vote_o);
        end
      end
    end
  end

  initial begin
    point_t a, b, c, p;
    turn_t  t;
    int     base;
    clear_gesture();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Steps[i]) begin
      p.x = Steps[i].x;
      p.y = Steps[i].y;
      t.cw = Steps[i].cw;
      t.vote = Steps[i].vote;
      offer_point(p, Steps[i].fin, Steps[i].typed, t);
    end

    a = any_point();
    b = any_point();
    c = any_point();
    saturating_gesture(a, b, c);
    saturating_gesture(a, c, b);

    base = items_sent;
    while (items_sent - base < RandomItems) begin
      if (items_sent - base > RandomItems * 9 / 10) quiet = 1'b1;
      random_gesture();
    end
    quiet = 1'b1;
    in_valid_i <= 1'b0;

    while (pending_turns.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_turns.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
